/* design/strict_utf8_to_utf16_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the strict UTF-8 to UTF-16 decoder
// Concurrent checks with reset disable; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STRICT_UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define STRICT_UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define SU8D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SU8D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SU8D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define SU8D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/su8d_pkg.sv */
// ----------------------------------------------------------------------------
// su8d_pkg
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package su8d_pkg;

  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [15:0] code_unit;
    kind_e       kind;
  } result_t;

  // one decoded input byte: up to three results
  typedef struct packed {
    logic               valid;
    logic [1:0]         count;
    result_t [2:0]      res;
  } step_out_t;

  localparam logic [7:0]  ASCII_MAX   = 8'h7F;
  localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
  localparam logic [20:0] MIN_CP2     = 21'h000080;
  localparam logic [20:0] MIN_CP3     = 21'h000800;
  localparam logic [20:0] MIN_CP4     = 21'h010000;
  localparam logic [20:0] SURR_MIN    = 21'h00D800;
  localparam logic [20:0] SURR_MAX    = 21'h00DFFF;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

endpackage

/* design/su8d_if.sv */
// ----------------------------------------------------------------------------
// su8d_in_if / su8d_out_if
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
interface su8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_of_string;

  modport source (output valid, output in_byte, output last_of_string, input ready);
  modport sink   (input valid, input in_byte, input last_of_string, output ready);
endinterface

interface su8d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  result_kind;
  logic        last_result;

  modport source (output valid, output code_unit, output result_kind,
                  output last_result, input ready);
  modport sink   (input valid, input code_unit, input result_kind,
                  input last_result, output ready);
endinterface

/* design/su8d_step.sv */
// ----------------------------------------------------------------------------
// su8d_step
// Input register, decoder state and per-byte decode into a result bundle.
// ----------------------------------------------------------------------------
`include "strict_utf8_to_utf16_decoder_unit_defines.svh"

module su8d_step
  import su8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  su8d_in_if.sink    in_i,
  input  logic       bnd_ready_i,
  output step_out_t  bnd_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;

  logic [2:0]  seq_q, seq_d;
  logic [1:0]  rem_q, rem_d;
  logic [20:0] acc_q, acc_d;
  logic        err_q, err_d;

  logic        adv;
  logic        bad;
  logic        emit;
  logic        has_tail;
  kind_e       tail_kind;
  logic [20:0] cp;
  logic [20:0] cont_cp;
  logic [1:0]  rem_dec;
  logic [20:0] v;
  logic        pair;
  logic [15:0] unit_a, unit_b;
  logic [1:0]  n_units;
  result_t     tail_res, res_a, res_b;

  assign adv        = in_valid_q && bnd_ready_i;
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      last_q <= in_i.last_of_string;
    end
  end

  assign cont_cp = {acc_q[14:0], byte_q[5:0]};
  assign rem_dec = rem_q - 2'd1;

  always_comb begin
    seq_d     = seq_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    err_d     = err_q;
    bad       = 1'b0;
    emit      = 1'b0;
    has_tail  = 1'b0;
    tail_kind = KIND_END;
    cp        = '0;
    if (err_q) begin
      if (last_q) begin
        err_d = 1'b0;
      end
    end else begin
      if (rem_q == 2'd0) begin
        if (byte_q <= ASCII_MAX) begin
          emit = 1'b1;
          cp   = {13'd0, byte_q};
        end else if (byte_q inside {[LEAD2_MIN:LEAD2_MAX]}) begin
          acc_d = {16'd0, byte_q[4:0]};
          seq_d = 3'd2;
          rem_d = 2'd1;
        end else if (byte_q inside {[LEAD3_MIN:LEAD3_MAX]}) begin
          acc_d = {17'd0, byte_q[3:0]};
          seq_d = 3'd3;
          rem_d = 2'd2;
        end else if (byte_q inside {[LEAD4_MIN:LEAD4_MAX]}) begin
          acc_d = {18'd0, byte_q[2:0]};
          seq_d = 3'd4;
          rem_d = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else if (byte_q[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        acc_d = cont_cp;
        rem_d = rem_dec;
        if (rem_dec == 2'd0) begin
          if ((seq_q == 3'd2 && cont_cp < MIN_CP2) ||
              (seq_q == 3'd3 && cont_cp < MIN_CP3) ||
              (seq_q == 3'd4 && cont_cp < MIN_CP4) ||
              (cont_cp inside {[SURR_MIN:SURR_MAX]}) ||
              (cont_cp > CP_MAX)) begin
            bad = 1'b1;
          end else begin
            emit = 1'b1;
            cp   = cont_cp;
          end
          seq_d = 3'd0;
          acc_d = '0;
        end
      end
      if (!bad && last_q && rem_d != 2'd0) begin
        bad = 1'b1;
      end
      if (bad || last_q) begin
        has_tail  = 1'b1;
        tail_kind = bad ? KIND_ERROR : KIND_END;
        seq_d     = 3'd0;
        rem_d     = 2'd0;
        acc_d     = '0;
        err_d     = bad && !last_q;
      end
    end
  end

  assign pair   = cp > BMP_MAX;
  assign v      = cp - MIN_CP4;
  assign unit_a = pair ? {HI_SURR_TAG, v[19:10]} : cp[15:0];
  assign unit_b = {LO_SURR_TAG, v[9:0]};

  assign n_units  = emit ? (pair ? 2'd2 : 2'd1) : 2'd0;
  assign tail_res = '{code_unit: 16'd0, kind: tail_kind};
  assign res_a    = '{code_unit: unit_a, kind: KIND_UNIT};
  assign res_b    = '{code_unit: unit_b, kind: KIND_UNIT};

  always_comb begin
    bnd_o.valid = in_valid_q;
    bnd_o.count = n_units + {1'b0, has_tail};
    bnd_o.res   = '{default: '0};
    case (n_units)
      2'd0: begin
        bnd_o.res[0] = tail_res;
      end
      2'd1: begin
        bnd_o.res[0] = res_a;
        bnd_o.res[1] = tail_res;
      end
      2'd2: begin
        bnd_o.res[0] = res_a;
        bnd_o.res[1] = res_b;
        bnd_o.res[2] = tail_res;
      end
      default: begin
        bnd_o.res[0] = tail_res;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
      rem_q <= '0;
      acc_q <= '0;
      err_q <= 1'b0;
    end else if (adv) begin
      seq_q <= seq_d;
      rem_q <= rem_d;
      acc_q <= acc_d;
      err_q <= err_d;
    end
  end

  `SU8D_ASSERT_IMP(a_idle_clean, clk_i, rst_ni, err_q || rem_q == 2'd0, seq_q == 3'd0 && acc_q == '0, "state not clear while idle or swallowing")
  `SU8D_ASSERT_IMP(a_seq_len, clk_i, rst_ni, rem_q != 2'd0, seq_q > {1'b0, rem_q} && !err_q, "sequence length inconsistent")
  `SU8D_ASSERT_NXT(a_end_clears, clk_i, rst_ni, adv && last_q, rem_q == 2'd0 && !err_q, "end of string left state behind")

endmodule

/* design/su8d_serializer.sv */
// ----------------------------------------------------------------------------
// su8d_serializer
// Holds one result bundle and sends its results one transaction at a time.
// ----------------------------------------------------------------------------
`include "strict_utf8_to_utf16_decoder_unit_defines.svh"

module su8d_serializer
  import su8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_out_t  bnd_i,
  output logic       bnd_ready_o,
  su8d_out_if.source out_o
);

  logic          valid_q;
  logic [1:0]    cnt_q;
  logic [1:0]    idx_q;
  result_t [2:0] res_q;
  logic          at_last;
  logic          free;
  logic          load;

  assign at_last     = idx_q == (cnt_q - 2'd1);
  assign free        = !valid_q || (out_o.ready && at_last);
  assign bnd_ready_o = free;
  assign load        = bnd_i.valid && free && (bnd_i.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      cnt_q   <= bnd_i.count;
      idx_q   <= '0;
    end else if (valid_q && out_o.ready) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= bnd_i.res;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.code_unit   = res_q[idx_q].code_unit;
  assign out_o.result_kind = res_q[idx_q].kind;
  assign out_o.last_result = valid_q && at_last;

  `SU8D_ASSERT_IMP(a_idx_range, clk_i, rst_ni, valid_q, idx_q < cnt_q, "result index past bundle count")
  `SU8D_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, valid_q && !out_o.ready, valid_q && $stable(idx_q) && $stable(cnt_q), "stalled bundle moved")
  `SU8D_ASSERT_NXT(a_new_bundle, clk_i, rst_ni, valid_q && out_o.ready && at_last, !valid_q || idx_q == 2'd0, "bundle did not restart at first result")

endmodule

/* design/strict_utf8_to_utf16_decoder_unit.sv */
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16_decoder_unit
// Strict streaming UTF-8 to UTF-16 decoder, one byte per transaction.
// ----------------------------------------------------------------------------
// Input channel in_i carries one UTF-8 byte and a last-of-string flag. Output
// channel out_o carries a 16-bit code unit, a result kind (unit, clean end,
// invalid) and last_result, set on the final result caused by one byte.
// A byte yields zero to three results: a unit or a surrogate pair, followed
// on the final byte of a string by an end result. A byte that shows an error
// yields only an invalid result, and the rest of the string is swallowed.
// A byte passes through the input register, then the output bundle register,
// which it holds until all its results are sent. Throughput is one byte per
// cycle for bytes with at most one result while the receiver is ready; the
// output register, one result per cycle, sets the rate otherwise.
// Reset clears the decode state and empties both registers. When the
// receiver stalls, the current result holds and the input stops accepting
// once the input register is full.
// ----------------------------------------------------------------------------
module strict_utf8_to_utf16_decoder_unit
  import su8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  su8d_in_if.sink    in_i,
  su8d_out_if.source out_o
);

  step_out_t bnd;
  logic      bnd_ready;

  su8d_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .bnd_ready_i (bnd_ready),
    .bnd_o       (bnd)
  );

  su8d_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_i       (bnd),
    .bnd_ready_o (bnd_ready),
    .out_o       (out_o)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strict UTF-8 to UTF-16 decoder. A short table of
// directed bytes, then random strings, mostly well formed with some broken
// ones, run under several idle/stall patterns. Every output transaction is
// compared against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb;
  import su8d_pkg::*;

  localparam int RAND_ITEMS = 330;
  localparam int HOLD_CYCLES = 120;
  localparam int WD_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int NDIR = 27;

  typedef struct packed {
    logic [15:0] unit;
    kind_e       kind;
    logic        last;
  } dec_res_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic        typed;
    kind_e       kind;
    logic [15:0] unit;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  su8d_in_if  in_if ();
  su8d_out_if out_if ();

  strict_utf8_to_utf16_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // typed rows override the final result of their byte
  dir_row_t dir_tab [NDIR] = '{
    '{8'h00, 1'b0, 1'b1, KIND_UNIT,  16'h0000},
    '{8'h7F, 1'b0, 1'b1, KIND_UNIT,  16'h007F},
    '{8'hEF, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'hBF, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'hBF, 1'b0, 1'b1, KIND_UNIT,  16'hFFFF},
    '{8'hF4, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h8F, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'hBF, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'hBF, 1'b1, 1'b1, KIND_END,   16'h0000},
    '{8'hC0, 1'b1, 1'b1, KIND_ERROR, 16'h0000},
    '{8'h80, 1'b0, 1'b1, KIND_ERROR, 16'h0000},
    '{8'hFF, 1'b1, 1'b0, KIND_UNIT,  16'h0000},
    '{8'hE0, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h80, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h80, 1'b1, 1'b1, KIND_ERROR, 16'h0000},
    '{8'hED, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'hA0, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h80, 1'b1, 1'b1, KIND_ERROR, 16'h0000},
    '{8'hF4, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h90, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h80, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h80, 1'b1, 1'b1, KIND_ERROR, 16'h0000},
    '{8'h41, 1'b0, 1'b1, KIND_UNIT,  16'h0041},
    '{8'hC2, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h41, 1'b1, 1'b1, KIND_ERROR, 16'h0000},
    '{8'hF0, 1'b0, 1'b0, KIND_UNIT,  16'h0000},
    '{8'h90, 1'b1, 1'b1, KIND_ERROR, 16'h0000}
  };

  dec_res_t pending_results[$];
  dec_res_t want;

  logic [2:0]  seq_len = '0;
  logic [1:0]  need_cont = '0;
  logic [20:0] cp_acc = '0;
  logic        swallowing = 1'b0;

  logic        cur_typed;
  kind_e       cur_kind;
  logic [15:0] cur_unit;

  int  phase;
  logic hold_req;
  logic hold_done;
  int  idle_cycles = 0;
  int  counted_items = 0;
  int  bytes_in = 0;
  int  results_out = 0;
  int  strings_done = 0;
  int  invalid_seen = 0;
  int  errors = 0;
  int  rand_base;
  int  seg;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit src_gap();
    if (hold_req && !hold_done) return 1'b0;
    case (phase)
      1: return $urandom_range(99) < 69;
      3: return $urandom_range(99) < 11;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit sink_gap();
    case (phase)
      2: return $urandom_range(99) < 69;
      3: return $urandom_range(99) < 11;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_decode();
    seq_len = '0;
    need_cont = '0;
    cp_acc = '0;
    swallowing = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic l,
                                      input logic typed, input kind_e tk,
                                      input logic [15:0] tu);
    logic        bad;
    logic        emit;
    logic [20:0] cp;
    logic [20:0] v;
    logic [15:0] u [3];
    kind_e       k [3];
    int          n;
    dec_res_t    r;
    bad = 1'b0;
    emit = 1'b0;
    cp = '0;
    n = 0;
    if (swallowing) begin
      if (l) clear_decode();
      return;
    end
    if (need_cont == 2'd0) begin
      if (b <= ASCII_MAX) begin
        cp = {13'd0, b};
        emit = 1'b1;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        cp_acc = {16'd0, b[4:0]};
        seq_len = 3'd2;
        need_cont = 2'd1;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        cp_acc = {17'd0, b[3:0]};
        seq_len = 3'd3;
        need_cont = 2'd2;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        cp_acc = {18'd0, b[2:0]};
        seq_len = 3'd4;
        need_cont = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      cp = {cp_acc[14:0], b[5:0]};
      cp_acc = cp;
      need_cont = need_cont - 2'd1;
      if (need_cont == 2'd0) begin
        if ((seq_len == 3'd2 && cp < MIN_CP2) || (seq_len == 3'd3 && cp < MIN_CP3) ||
            (seq_len == 3'd4 && cp < MIN_CP4) || (cp >= SURR_MIN && cp <= SURR_MAX) ||
            cp > CP_MAX) begin
          bad = 1'b1;
        end else begin
          emit = 1'b1;
        end
        seq_len = '0;
        cp_acc = '0;
      end
    end
    if (emit) begin
      if (cp <= BMP_MAX) begin
        u[n] = cp[15:0];
        k[n] = KIND_UNIT;
        n++;
      end else begin
        v = cp - MIN_CP4;
        u[n] = 16'hD800 + {6'd0, v[19:10]};
        k[n] = KIND_UNIT;
        n++;
        u[n] = 16'hDC00 + {6'd0, v[9:0]};
        k[n] = KIND_UNIT;
        n++;
      end
    end
    if (!bad && l && need_cont != 2'd0) bad = 1'b1;
    if (bad) begin
      u[n] = '0;
      k[n] = KIND_ERROR;
      n++;
      clear_decode();
      if (!l) swallowing = 1'b1;
    end else if (l) begin
      u[n] = '0;
      k[n] = KIND_END;
      n++;
      clear_decode();
    end
    if (n > 0 && typed) begin
      u[n-1] = tu;
      k[n-1] = tk;
    end
    for (int i = 0; i < n; i++) begin
      r.unit = u[i];
      r.kind = k[i];
      r.last = (i == n - 1);
      pending_results = {pending_results, r};
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input kind_e tk, input logic [15:0] tu);
    while (src_gap()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.last_of_string <= l;
    cur_typed <= typed;
    cur_kind <= tk;
    cur_unit <= tu;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  task automatic send_string();
    logic [7:0]  s[$];
    logic [20:0] cp;
    int          mode;
    int          ncp;
    mode = $urandom_range(99);
    if (mode < 8) begin
      ncp = $urandom_range(1, 4);
      repeat (ncp) s = {s, 8'($urandom_range(255))};
    end else begin
      ncp = $urandom_range(1, 6);
      repeat (ncp) begin
        case ($urandom_range(3))
          0: cp = 21'($urandom_range(0, 127));
          1: cp = 21'($urandom_range(128, 2047));
          2: cp = 21'($urandom_range(2048, 65535));
          default: cp = 21'($urandom_range(65536, 1114111));
        endcase
        if (cp >= SURR_MIN && cp <= SURR_MAX) cp = cp ^ 21'h002000;
        if (cp < MIN_CP2) begin
          s = {s, cp[7:0]};
        end else if (cp < MIN_CP3) begin
          s = {s, {3'b110, cp[10:6]}};
          s = {s, {2'b10, cp[5:0]}};
        end else if (cp < MIN_CP4) begin
          s = {s, {4'b1110, cp[15:12]}};
          s = {s, {2'b10, cp[11:6]}};
          s = {s, {2'b10, cp[5:0]}};
        end else begin
          s = {s, {5'b11110, cp[20:18]}};
          s = {s, {2'b10, cp[17:12]}};
          s = {s, {2'b10, cp[11:6]}};
          s = {s, {2'b10, cp[5:0]}};
        end
      end
      if (mode >= 80) begin
        case ($urandom_range(3))
          0: s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
          1: if (s.size() > 1) void'(s.pop_back());
          2: begin
            case ($urandom_range(5))
              0: begin
                s = {s, 8'hC0 | 8'($urandom_range(1))};
                s = {s, cont_byte()};
              end
              1: begin
                s = {s, 8'hE0};
                s = {s, 8'h80 | 8'($urandom_range(31))};
                s = {s, cont_byte()};
              end
              2: begin
                s = {s, 8'hF0};
                s = {s, 8'h80 | 8'($urandom_range(15))};
                s = {s, cont_byte()};
                s = {s, cont_byte()};
              end
              3: begin
                s = {s, 8'hED};
                s = {s, 8'hA0 | 8'($urandom_range(31))};
                s = {s, cont_byte()};
              end
              4: begin
                s = {s, 8'hF4};
                s = {s, 8'h90 | 8'($urandom_range(47))};
                s = {s, cont_byte()};
                s = {s, cont_byte()};
              end
              default: s = {s, 8'($urandom_range(8'hF5, 8'hFF))};
            endcase
            repeat ($urandom_range(2)) s = {s, 8'($urandom_range(127))};
          end
          default: begin
            s = {s, 8'($urandom_range(LEAD2_MIN, LEAD2_MAX))};
            if ($urandom_range(1)) s = {s, 8'($urandom_range(127))};
            else s = {s, 8'($urandom_range(8'hC0, 8'hFF))};
            repeat ($urandom_range(2)) s = {s, 8'($urandom_range(127))};
          end
        endcase
      end
    end
    foreach (s[i]) send_byte(s[i], i == s.size() - 1, 1'b0, KIND_UNIT, 16'h0000);
  endtask

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_if.ready <= !sink_gap();
      end
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_out++;
        if (out_if.result_kind == KIND_END || out_if.result_kind == KIND_ERROR)
          strings_done++;
        if (out_if.result_kind == KIND_ERROR) invalid_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: unit %h kind %0d last %b", $time,
                   out_if.code_unit, out_if.result_kind, out_if.last_result);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (want.unit !== out_if.code_unit || want.kind !== out_if.result_kind ||
              want.last !== out_if.last_result) begin
            $display({"%0t mismatch: expected unit %h kind %0d last %b, ",
                      "actual unit %h kind %0d last %b"},
                     $time, want.unit, want.kind, want.last,
                     out_if.code_unit, out_if.result_kind, out_if.last_result);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (!swallowing) counted_items++;
        bytes_in++;
        decode_byte(in_if.in_byte, in_if.last_of_string, cur_typed, cur_kind, cur_unit);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.last_of_string = 1'b0;
    cur_typed = 1'b0;
    cur_kind = KIND_UNIT;
    cur_unit = '0;
    phase = 0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      begin
        foreach (dir_tab[i])
          send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed,
                    dir_tab[i].kind, dir_tab[i].unit);
        rand_base = counted_items;
        for (seg = 0; seg < 8; seg++) begin
          phase = seg % 4;
          if (seg == 4) hold_req <= 1'b1;
          if (seg == 5) begin
            in_if.valid <= 1'b0;
            @(posedge clk_i);
            wait (pending_results.size() == 0);
          end
          while (counted_items < rand_base + RAND_ITEMS * (seg + 1) / 8) send_string();
        end
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      wait (idle_cycles >= WD_LIMIT);
    join_any
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, WD_LIMIT);
    end
    $display("decoded %0d input bytes into %0d results over %0d strings (%0d invalid)",
             bytes_in, results_out, strings_done, invalid_seen);
    $display("idle patterns: none, sender, receiver, both; one long receiver hold; %0d errors",
             errors);
    if (errors == 0 && idle_cycles < WD_LIMIT) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
